// ===== hdl/pgn_pkg.sv =====
// Shared constants and types for the gradient noise block.
`timescale 1ns / 1ps
package pgn_pkg;
    localparam int TBL_AW   = 8;
    localparam int FRAC     = 16;
    localparam int MAX_OCT  = 8;
    localparam int MUL_W    = 22;

    localparam logic [2:0] KIND_GRAD   = 3'd0;
    localparam logic [2:0] KIND_PERM_X = 3'd1;
    localparam logic [2:0] KIND_PERM_Y = 3'd2;
    localparam logic [2:0] KIND_PERM_Z = 3'd3;
    localparam logic [2:0] KIND_NOISE  = 3'd4;
    localparam logic [2:0] KIND_TURB   = 3'd5;

    typedef struct packed {
        logic              we_grad;
        logic              we_px;
        logic              we_py;
        logic              we_pz;
        logic [TBL_AW-1:0] idx;
        logic [47:0]       grad;
        logic [7:0]        perm;
    } t_tbl_wr;

    typedef struct packed {
        logic              perm_re;
        logic              grad_re;
        logic [TBL_AW-1:0] ax;
        logic [TBL_AW-1:0] ay;
        logic [TBL_AW-1:0] az;
        logic [TBL_AW-1:0] ag;
    } t_tbl_rd;

    typedef struct packed {
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  pz;
        logic [47:0] grad;
    } t_tbl_rsp;
endpackage

// ===== hdl/pgn_tables.sv =====
// Gradient and permutation table memories with registered reads.
`timescale 1ns / 1ps
module pgn_tables (
    input  logic              i_clk,
    input  pgn_pkg::t_tbl_wr  i_wr,
    input  pgn_pkg::t_tbl_rd  i_rd,
    output pgn_pkg::t_tbl_rsp o_rsp
);
    localparam int DEPTH = 1 << pgn_pkg::TBL_AW;

    logic [47:0] r_grad_mem [DEPTH];
    logic [7:0]  r_px_mem   [DEPTH];
    logic [7:0]  r_py_mem   [DEPTH];
    logic [7:0]  r_pz_mem   [DEPTH];
    logic [47:0] r_grad_q;
    logic [7:0]  r_px_q, r_py_q, r_pz_q;

    // Write loads and read the three permutation tables
    always_ff @(posedge i_clk) begin
        if (i_wr.we_px) r_px_mem[i_wr.idx] <= i_wr.perm;
        if (i_wr.we_py) r_py_mem[i_wr.idx] <= i_wr.perm;
        if (i_wr.we_pz) r_pz_mem[i_wr.idx] <= i_wr.perm;
        if (i_rd.perm_re) begin
            r_px_q <= r_px_mem[i_rd.ax];
            r_py_q <= r_py_mem[i_rd.ay];
            r_pz_q <= r_pz_mem[i_rd.az];
        end
    end

    // Gradient table; hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_wr.we_grad) r_grad_mem[i_wr.idx] <= i_wr.grad;
        if (i_rd.grad_re) r_grad_q <= r_grad_mem[i_rd.ag];
    end

    assign o_rsp.px   = r_px_q;
    assign o_rsp.py   = r_py_q;
    assign o_rsp.pz   = r_pz_q;
    assign o_rsp.grad = r_grad_q;
endmodule

// ===== hdl/pgn_core.sv =====
// Query sequencer: fades, corner hashing, weighted dot sums, octaves.
`timescale 1ns / 1ps
module pgn_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_kind,
    input  logic [159:0]      i_data,
    input  logic [3:0]        i_oct_cnt,
    output pgn_pkg::t_tbl_wr  o_wr,
    output pgn_pkg::t_tbl_rd  o_rd,
    input  pgn_pkg::t_tbl_rsp i_rsp,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [18:0]       o_res
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_F1    = 4'd2;
    localparam logic [3:0] S_F2    = 4'd3;
    localparam logic [3:0] S_F3    = 4'd4;
    localparam logic [3:0] S_PERM  = 4'd5;
    localparam logic [3:0] S_HASH  = 4'd6;
    localparam logic [3:0] S_W2    = 4'd7;
    localparam logic [3:0] S_GX    = 4'd8;
    localparam logic [3:0] S_GY    = 4'd9;
    localparam logic [3:0] S_GZ    = 4'd10;
    localparam logic [3:0] S_DOT   = 4'd11;
    localparam logic [3:0] S_DW    = 4'd12;
    localparam logic [3:0] S_ACC   = 4'd13;
    localparam logic [3:0] S_OCT   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    localparam int FR = pgn_pkg::FRAC;
    localparam int MW = pgn_pkg::MUL_W;
    localparam logic signed [MW-1:0] THREE = MW'(3 << FR);
    localparam logic [16:0] ONE = 17'(1 << FR);

    logic [3:0]  r_state;
    logic        r_turb;
    logic [2:0]  r_oct;
    logic [3:0]  r_noct;
    logic [23:0] r_pt [3];
    logic [7:0]  r_ip [3];
    logic [15:0] r_fr [3];
    logic [16:0] r_fd [3];
    logic [1:0]  r_axis;
    logic [2:0]  r_corner;
    logic [16:0] r_w;
    logic signed [34:0] r_dot;
    logic signed [25:0] r_noise;
    logic signed [31:0] r_sum;
    logic signed [2*MW-1:0] r_prod;
    logic signed [MW-1:0] n_ma, n_mb;

    logic [15:0] fr_a;
    logic [16:0] wx, wy, wz;
    logic signed [16:0] ox, oy, oz;
    logic signed [15:0] gx, gy, gz;
    logic [3:0]  oct_lim;
    logic signed [31:0] res_abs;
    logic [23:0] pt_s [3];

    assign fr_a = r_fr[r_axis];
    assign wx = r_corner[2] ? r_fd[0] : ONE - r_fd[0];
    assign wy = r_corner[1] ? r_fd[1] : ONE - r_fd[1];
    assign wz = r_corner[0] ? r_fd[2] : ONE - r_fd[2];
    assign ox = {r_corner[2], r_fr[0]};
    assign oy = {r_corner[1], r_fr[1]};
    assign oz = {r_corner[0], r_fr[2]};
    assign gx = i_rsp.grad[15:0];
    assign gy = i_rsp.grad[31:16];
    assign gz = i_rsp.grad[47:32];
    assign oct_lim = (i_oct_cnt > 4'(pgn_pkg::MAX_OCT)) ? 4'(pgn_pkg::MAX_OCT) : i_oct_cnt;

    // Scale the point for the current octave
    always_comb begin
        for (int a = 0; a < 3; a++) pt_s[a] = r_pt[a] << r_oct;
    end

    // Select operands of the shared multiplier
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_state)
            S_F1: begin
                n_ma = MW'({1'b0, fr_a});
                n_mb = MW'({1'b0, fr_a});
            end
            S_F2: begin
                n_ma = MW'({1'b0, r_prod[31:16]});
                n_mb = THREE - MW'({1'b0, fr_a, 1'b0});
            end
            S_HASH: begin
                n_ma = MW'({1'b0, wx});
                n_mb = MW'({1'b0, wy});
            end
            S_W2: begin
                n_ma = MW'({1'b0, r_prod[32:16]});
                n_mb = MW'({1'b0, wz});
            end
            S_GX: begin
                n_ma = MW'(gx);
                n_mb = MW'(ox);
            end
            S_GY: begin
                n_ma = MW'(gy);
                n_mb = MW'(oy);
            end
            S_GZ: begin
                n_ma = MW'(gz);
                n_mb = MW'(oz);
            end
            S_DW: begin
                n_ma = MW'($signed(r_dot[34:14]));
                n_mb = MW'({1'b0, r_w});
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
    end

    // Table writes from load items, reads from the corner walk
    always_comb begin
        o_wr.idx     = i_data[7:0];
        o_wr.grad    = i_data[55:8];
        o_wr.perm    = i_data[63:56];
        o_wr.we_grad = o_ready && i_valid && (i_kind == pgn_pkg::KIND_GRAD);
        o_wr.we_px   = o_ready && i_valid && (i_kind == pgn_pkg::KIND_PERM_X);
        o_wr.we_py   = o_ready && i_valid && (i_kind == pgn_pkg::KIND_PERM_Y);
        o_wr.we_pz   = o_ready && i_valid && (i_kind == pgn_pkg::KIND_PERM_Z);
        o_rd.perm_re = (r_state == S_PERM);
        o_rd.grad_re = (r_state == S_HASH);
        o_rd.ax      = r_ip[0] + 8'(r_corner[2]);
        o_rd.ay      = r_ip[1] + 8'(r_corner[1]);
        o_rd.az      = r_ip[2] + 8'(r_corner[0]);
        o_rd.ag      = i_rsp.px ^ i_rsp.py ^ i_rsp.pz;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);

    // Absolute value in turbulence mode, then saturate
    always_comb begin
        res_abs = (r_turb && r_sum < 0) ? -r_sum : r_sum;
        if (res_abs > 32'sd262143)       o_res = 19'h3FFFF;
        else if (res_abs < -32'sd262144) o_res = 19'h40000;
        else                             o_res = res_abs[18:0];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && (i_kind == pgn_pkg::KIND_NOISE ||
                                    i_kind == pgn_pkg::KIND_TURB)) begin
                        r_turb  <= (i_kind == pgn_pkg::KIND_TURB);
                        r_pt[0] <= i_data[87:64];
                        r_pt[1] <= i_data[119:96];
                        r_pt[2] <= i_data[151:128];
                        r_oct   <= '0;
                        r_noct  <= oct_lim;
                        r_noise <= '0;
                        r_sum   <= '0;
                        if (i_kind == pgn_pkg::KIND_TURB && oct_lim == 4'd0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    for (int a = 0; a < 3; a++) begin
                        r_ip[a] <= pt_s[a][23:16];
                        r_fr[a] <= pt_s[a][15:0];
                    end
                    r_axis  <= '0;
                    r_state <= S_F1;
                end
                S_F1: r_state <= S_F2;
                S_F2: r_state <= S_F3;
                S_F3: begin
                    r_fd[r_axis] <= r_prod[32:16];
                    r_corner     <= '0;
                    if (r_axis == 2'd2) begin
                        r_state <= S_PERM;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_F1;
                    end
                end
                S_PERM: r_state <= S_HASH;
                S_HASH: r_state <= S_W2;
                S_W2:   r_state <= S_GX;
                S_GX: begin
                    r_w     <= r_prod[32:16];
                    r_state <= S_GY;
                end
                S_GY: begin
                    r_dot   <= r_prod[34:0];
                    r_state <= S_GZ;
                end
                S_GZ: begin
                    r_dot   <= r_dot + r_prod[34:0];
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    r_dot   <= r_dot + r_prod[34:0];
                    r_state <= S_DW;
                end
                S_DW: r_state <= S_ACC;
                S_ACC: begin
                    r_noise  <= r_noise + 26'($signed(r_prod[38:16]));
                    r_corner <= r_corner + 3'd1;
                    r_state  <= (r_corner == 3'd7) ? S_OCT : S_PERM;
                end
                S_OCT: begin
                    r_sum   <= r_sum + (32'(r_noise) >>> r_oct);
                    r_noise <= '0;
                    if (r_turb && (4'(r_oct) + 4'd1 < r_noct)) begin
                        r_oct   <= r_oct + 3'd1;
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/perlin_gradient_noise.sv =====
// Top level of the 3-D gradient noise block with turbulence mode.
//
//  channel   | direction | tdata / tuser contents
//  s_axis    | in        | tdata: index, grad x/y/z, perm value, point x/y/z; tuser: kind
//  m_axis    | out       | tdata: noise value (Q3.16)
//  cfg       | in        | octave count
//
// A load item is written to its table when accepted. An octave runs a setup step, a fade
// for each of the three axes and a step sequence for each of the eight corners, then closes
// the octave. A noise query runs one octave, a turbulence query one per configured octave
// (at most eight). Query time is set by one shared multiplier used in turn for fades,
// corner weights and the gradient dot product, and by the single table read ports.
// Reset is synchronous, active low; table contents are undefined until loaded.
// A stalled result sits in the output register while the next item is taken.
`timescale 1ns / 1ps
module perlin_gradient_noise (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] table_index, [23:8] grad_x, [39:24] grad_y, [55:40] grad_z,
    // [63:56] perm_value, [95:64] point_x, [127:96] point_y, [159:128] point_z
    input  logic [159:0] s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [18:0] noise_value
    output logic [23:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata
);
    pgn_pkg::t_tbl_wr  tbl_wr;
    pgn_pkg::t_tbl_rd  tbl_rd;
    pgn_pkg::t_tbl_rsp tbl_rsp;
    logic [3:0]  r_oct_cnt;
    logic        r_ovalid;
    logic [18:0] r_odata;
    logic        res_valid, res_ready;
    logic [18:0] res;

    // Hold the octave count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cnt <= 4'd7;
        end else if (i_cfg_we) begin
            r_oct_cnt <= i_cfg_wdata;
        end
    end

    pgn_tables u_tables (
        .i_clk (i_clk),
        .i_wr  (tbl_wr),
        .i_rd  (tbl_rd),
        .o_rsp (tbl_rsp)
    );

    pgn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_oct_cnt   (r_oct_cnt),
        .o_wr        (tbl_wr),
        .o_rd        (tbl_rd),
        .i_rsp       (tbl_rsp),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: load a result when empty or being drained
    assign res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_odata <= res;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_odata};
endmodule

// ===== test/tb_perlin_gradient_noise.sv =====
// Testbench for the gradient noise block: table loads, noise and turbulence queries.
`timescale 1ns / 1ps
module tb_perlin_gradient_noise;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 1200;

    typedef struct {
        logic [2:0]   kind;
        logic [159:0] data;
    } t_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [3:0]   i_cfg_wdata = '0;

    perlin_gradient_noise DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic signed [15:0] grad_mem [256][3];
    logic [7:0]         px_mem [256];
    logic [7:0]         py_mem [256];
    logic [7:0]         pz_mem [256];
    logic [3:0]         octaves;

    t_item         pending_items [$];
    logic [18:0]   expected_noise [$];
    int            mismatches = 0;
    int            cycles = 0;
    int            gap_left = 0;
    int            burst_left = 0;
    int            stall_phase = 0;
    bit            hold_idle = 1'b1;

    function automatic longint fsh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fade_of(longint u);
        longint t;
        t = (u * u) >>> pgn_pkg::FRAC;
        return (t * (3 * 65536 - 2 * u)) >>> pgn_pkg::FRAC;
    endfunction

    // Sum the eight weighted corner contributions at one scaled point
    function automatic longint lattice_noise(longint cx, longint cy, longint cz);
        longint c [3];
        int     ip [3];
        longint fr [3], fd [3];
        longint acc, wx, wy, wz, w, ox, oy, oz, dotp;
        int     h;
        c[0] = cx; c[1] = cy; c[2] = cz;
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            ip[a] = int'((c[a] >> pgn_pkg::FRAC) & 255);
            fr[a] = c[a] & 65535;
            fd[a] = fade_of(fr[a]);
        end
        for (int di = 0; di < 2; di++)
            for (int dj = 0; dj < 2; dj++)
                for (int dk = 0; dk < 2; dk++) begin
                    h = px_mem[(ip[0] + di) & 255] ^ py_mem[(ip[1] + dj) & 255]
                        ^ pz_mem[(ip[2] + dk) & 255];
                    wx = di ? fd[0] : 65536 - fd[0];
                    wy = dj ? fd[1] : 65536 - fd[1];
                    wz = dk ? fd[2] : 65536 - fd[2];
                    w  = (((wx * wy) >>> pgn_pkg::FRAC) * wz) >>> pgn_pkg::FRAC;
                    ox = fr[0] - (di ? 65536 : 0);
                    oy = fr[1] - (dj ? 65536 : 0);
                    oz = fr[2] - (dk ? 65536 : 0);
                    dotp = longint'(grad_mem[h][0]) * ox + longint'(grad_mem[h][1]) * oy
                        + longint'(grad_mem[h][2]) * oz;
                    dotp = fsh(dotp, 14);
                    acc += fsh(dotp * w, pgn_pkg::FRAC);
                end
        return acc;
    endfunction

    // Apply one item to the predictor; queue a result for queries
    task automatic predict_item(t_item it);
        logic [7:0] idx;
        longint     pt [3];
        longint     r;
        int         n;
        idx = it.data[7:0];
        case (it.kind)
            pgn_pkg::KIND_GRAD: begin
                grad_mem[idx][0] = it.data[23:8];
                grad_mem[idx][1] = it.data[39:24];
                grad_mem[idx][2] = it.data[55:40];
            end
            pgn_pkg::KIND_PERM_X: px_mem[idx] = it.data[63:56];
            pgn_pkg::KIND_PERM_Y: py_mem[idx] = it.data[63:56];
            pgn_pkg::KIND_PERM_Z: pz_mem[idx] = it.data[63:56];
            pgn_pkg::KIND_NOISE, pgn_pkg::KIND_TURB: begin
                pt[0] = longint'($signed(it.data[95:64]));
                pt[1] = longint'($signed(it.data[127:96]));
                pt[2] = longint'($signed(it.data[159:128]));
                if (it.kind == pgn_pkg::KIND_NOISE) begin
                    r = lattice_noise(pt[0], pt[1], pt[2]);
                end else begin
                    n = (octaves > pgn_pkg::MAX_OCT) ? pgn_pkg::MAX_OCT : octaves;
                    r = 0;
                    for (int o = 0; o < n; o++)
                        r += fsh(lattice_noise(pt[0] << o, pt[1] << o, pt[2] << o), o);
                    if (r < 0) r = -r;
                end
                if (r > 262143) r = 262143;
                if (r < -262144) r = -262144;
                expected_noise.push_back(r[18:0]);
            end
            default: ;
        endcase
    endtask

    function automatic t_item make_item(logic [2:0] k, logic [7:0] idx, logic [15:0] gx,
                                        logic [15:0] gy, logic [15:0] gz, logic [7:0] pv,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_item it;
        it.kind = k;
        it.data = {z, y, x, pv, gz, gy, gx, idx};
        return it;
    endfunction

    function automatic logic [15:0] rand_grad();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sd16384;
        if (r == 1) return -16'sd16384;
        if (r == 2) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return $urandom;
        if (r == 1) return 32'h7fffffff - $urandom_range(0, 3);
        if (r == 2) return 32'h80000000 + $urandom_range(0, 3);
        return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    function automatic t_item rand_query(bit turb);
        return make_item(turb ? pgn_pkg::KIND_TURB : pgn_pkg::KIND_NOISE, 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                         rand_coord(), rand_coord(), rand_coord());
    endfunction

    // Drive items in bursts with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                if (!hold_idle && pending_items.size() != 0
                        && (gap_left == 0 || burst_left != 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].kind;
                    s_axis_tdata  <= pending_items[0].data;
                    predict_item(pending_items.pop_front());
                    if (burst_left != 0) burst_left <= burst_left - 1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0 && burst_left == 0) gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Stall the result side on a repeating pattern with random stretches
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 97;
        m_axis_tready <= (stall_phase < 40) ? 1'b1 :
                         (stall_phase < 70) ? ($urandom_range(0, 2) != 0) : (stall_phase[0]);
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_noise.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise_value=%0d",
                             $signed(m_axis_tdata[18:0]));
            end else begin
                if (m_axis_tdata[18:0] !== expected_noise[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %0d actual %0d",
                                 $signed(expected_noise[0]), $signed(m_axis_tdata[18:0]));
                end
                void'(expected_noise.pop_front());
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || expected_noise.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_octaves(logic [3:0] v);
        drain();
        hold_idle = 1'b1;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        octaves = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        hold_idle = 1'b0;
    endtask

    initial begin
        logic [3:0] oct_plan [6];
        oct_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
        octaves = 4'd7;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every permutation entry with values below 64, so each hash lands
        // on one of the 64 gradients loaded here
        for (int i = 0; i < 256; i++) begin
            if (i < 64)
                pending_items.push_back(make_item(pgn_pkg::KIND_GRAD, i[7:0], rand_grad(),
                                                  rand_grad(), rand_grad(), '0, '0, '0, '0));
            pending_items.push_back(make_item(pgn_pkg::KIND_PERM_X, i[7:0], '0, '0, '0,
                                              8'($urandom_range(0, 63)), '0, '0, '0));
            pending_items.push_back(make_item(pgn_pkg::KIND_PERM_Y, i[7:0], '0, '0, '0,
                                              8'($urandom_range(0, 63)), '0, '0, '0));
            pending_items.push_back(make_item(pgn_pkg::KIND_PERM_Z, i[7:0], '0, '0, '0,
                                              8'($urandom_range(0, 63)), '0, '0, '0));
        end
        // Directed: extreme gradients, unused kinds, extreme points, both queries
        pending_items.push_back(make_item(pgn_pkg::KIND_GRAD, 8'd0, 16'h7fff, 16'h8000,
                                          16'hffff, 8'hff, '1, '1, '1));
        pending_items.push_back(make_item(pgn_pkg::KIND_GRAD, 8'd255, 16'sd16384,
                                          -16'sd16384, 16'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(3'd6, 8'hff, '1, '1, '1, '1, '1, '1, '1));
        pending_items.push_back(make_item(3'd7, 8'h00, '0, '0, '0, '0, '0, '0, '0));
        pending_items.push_back(make_item(pgn_pkg::KIND_NOISE, '0, '0, '0, '0, '0,
                                          '0, '0, '0));
        pending_items.push_back(make_item(pgn_pkg::KIND_NOISE, '1, '1, '1, '1, '1,
                                          32'h7fffffff, 32'h80000000, 32'hffffffff));
        pending_items.push_back(make_item(pgn_pkg::KIND_NOISE, '0, '0, '0, '0, '0,
                                          32'h0000ffff, 32'h00008000, 32'h00010000));
        pending_items.push_back(make_item(pgn_pkg::KIND_TURB, '0, '0, '0, '0, '0,
                                          32'h80000000, 32'h7fffffff, 32'h00018000));
        pending_items.push_back(make_item(pgn_pkg::KIND_TURB, '1, '1, '1, '1, '1,
                                          32'hffffffff, 32'h0, 32'h12345678));
        hold_idle = 1'b0;

        // Random phases over several octave settings
        foreach (oct_plan[p]) begin
            set_octaves(oct_plan[p]);
            for (int n = 0; n < 12; n++) begin
                int r;
                r = $urandom_range(0, 9);
                if (r < 3)
                    pending_items.push_back(rand_query(1'b0));
                else if (r < 5)
                    pending_items.push_back(rand_query(1'b1));
                else if (r < 9)
                    pending_items.push_back(make_item(3'($urandom_range(0, 3)), 8'($urandom),
                                                      rand_grad(), rand_grad(), 16'($urandom),
                                                      8'($urandom_range(0, 63)), $urandom,
                                                      $urandom, $urandom));
                else
                    pending_items.push_back(make_item(3'($urandom_range(6, 7)), 8'($urandom),
                                                      16'($urandom), 16'($urandom),
                                                      16'($urandom), 8'($urandom),
                                                      $urandom, $urandom, $urandom));
            end
        end
        drain();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/pgn_pkg.sv
hdl/pgn_tables.sv
hdl/pgn_core.sv
hdl/perlin_gradient_noise.sv
test/tb_perlin_gradient_noise.sv
